// ===== rtl/core/vector_interning_hash_table_defines.svh =====
// Assertion macros for the vector interning hash table.
// Used by vector_interning_hash_table.sv, the RTL file that carries concurrent checks.
`ifndef VECTOR_INTERNING_HASH_TABLE_DEFINES_SVH
`define VECTOR_INTERNING_HASH_TABLE_DEFINES_SVH

// Plain check, sampled on the rising clock edge, off during reset.
`define VIH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vih assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define VIH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vih assertion failed");

`endif

// ===== rtl/core/vih_pkg.sv =====
// Package for the vector interning hash table: sizes, codes, store request type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vih_pkg;

  localparam int ENTRY_CAPACITY = 256;
  localparam int SLOT_COUNT     = 512;
  localparam int MAX_KEY_LEN    = 16;

  localparam int ENTRY_W = $clog2(ENTRY_CAPACITY);
  localparam int CNT_W   = ENTRY_W + 1;
  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int LEN_W   = $clog2(MAX_KEY_LEN + 1);
  localparam int KIDX_W  = $clog2(MAX_KEY_LEN);
  localparam int KADDR_W = ENTRY_W + KIDX_W;
  localparam int SLOTE_W = ENTRY_W + 1;
  localparam int SYM_W   = 15;
  localparam int HASH_W  = 31;
  localparam int FUNC_W  = 2;

  localparam logic [HASH_W-1:0] HASH_MULT = HASH_W'(16807);

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
  // Unused code: the request is dropped.
  localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

  // Slot word: valid bit on top, entry index below.
  typedef struct packed {
    logic                 slot_we;
    logic [SLOT_W-1:0]    slot_waddr;
    logic [SLOTE_W-1:0]   slot_wdata;
    logic                 slot_re;
    logic [SLOT_W-1:0]    slot_raddr;
    logic                 len_we;
    logic [ENTRY_W-1:0]   len_waddr;
    logic [LEN_W-1:0]     len_wdata;
    logic                 len_re;
    logic [ENTRY_W-1:0]   len_raddr;
    logic                 key_we;
    logic [KADDR_W-1:0]   key_waddr;
    logic [SYM_W-1:0]     key_wdata;
    logic                 key_re;
    logic [KADDR_W-1:0]   key_raddr;
  } vih_store_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/vih_keybuf.sv =====
// Key assembly: hash accumulator, symbol buffer, length count, overflow mark.
// Depends on vih_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vih_keybuf
  import vih_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              sym_en_i,
  input  wire logic [SYM_W-1:0]  sym_i,
  input  wire logic              clr_i,
  input  wire logic [KIDX_W-1:0] rd_idx_i,
  output logic [SLOT_W-1:0]      home_slot_o,
  output logic [LEN_W-1:0]       len_o,
  output logic                   ovf_o,
  output logic [SYM_W-1:0]       rd_sym_o
);

  logic [HASH_W-1:0] hash_q, hash_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [SYM_W-1:0]  buf_q [MAX_KEY_LEN];
  logic [HASH_W:0]   hash_sum;
  logic [HASH_W+SYM_W:0] hash_prod;
  logic              room;

  assign room      = (len_q < LEN_W'(MAX_KEY_LEN));
  assign hash_sum  = {1'b0, hash_q} + (HASH_W+1)'(sym_i);
  assign hash_prod = (HASH_W+SYM_W+1)'(hash_sum) * (HASH_W+SYM_W+1)'(HASH_MULT);

  always_comb begin
    hash_d = hash_q;
    len_d  = len_q;
    ovf_d  = ovf_q;
    if (clr_i) begin
      hash_d = '0;
      len_d  = '0;
      ovf_d  = 1'b0;
    end else if (sym_en_i) begin
      hash_d = hash_prod[HASH_W-1:0];
      if (room) len_d = len_q + LEN_W'(1);
      else      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      len_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      hash_q <= hash_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!clr_i && sym_en_i && room) buf_q[len_q[KIDX_W-1:0]] <= sym_i;
  end

  assign home_slot_o = hash_q[SLOT_W-1:0];
  assign len_o       = len_q;
  assign ovf_o       = ovf_q;
  assign rd_sym_o    = buf_q[rd_idx_i];

endmodule

`default_nettype wire

// ===== rtl/core/vih_store.sv =====
// Table storage: slot table, key length store and key symbol store.
// One write and one registered read per memory. Depends on vih_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vih_store
  import vih_pkg::*;
(
  input  wire logic           clk_i,
  input  wire vih_store_req_t req_i,
  output logic [SLOTE_W-1:0]  slot_rd_o,
  output logic [LEN_W-1:0]    len_rd_o,
  output logic [SYM_W-1:0]    key_rd_o
);

  logic [SLOTE_W-1:0] slot_mem [SLOT_COUNT];
  logic [LEN_W-1:0]   len_mem  [ENTRY_CAPACITY];
  logic [SYM_W-1:0]   key_mem  [ENTRY_CAPACITY*MAX_KEY_LEN];

  always_ff @(posedge clk_i) begin
    if (req_i.slot_we) slot_mem[req_i.slot_waddr] <= req_i.slot_wdata;
    if (req_i.slot_re) slot_rd_o <= slot_mem[req_i.slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.len_we) len_mem[req_i.len_waddr] <= req_i.len_wdata;
    if (req_i.len_re) len_rd_o <= len_mem[req_i.len_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.key_we) key_mem[req_i.key_waddr] <= req_i.key_wdata;
    if (req_i.key_re) key_rd_o <= key_mem[req_i.key_raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/vector_interning_hash_table.sv =====
// Symbol items feed the hash at one per cycle while idle with no result pending.
// A key end runs a probe walk: the home slot, a read and check per slot visited,
// a length check and a read and check per compared symbol. An insert miss writes
// each symbol, then the length and slot. Reads fetch the length, then each stored
// symbol. Reset clears control, then sweeps all 512 slots before any request.
`timescale 1ns / 1ps
`default_nettype none

module vector_interning_hash_table
  import vih_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FUNC_W-1:0]  func_i,
  input  wire logic [SYM_W-1:0]   symbol_i,
  input  wire logic               symbol_present_i,
  input  wire logic               last_symbol_i,
  input  wire logic [ENTRY_W-1:0] read_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [ENTRY_W-1:0]      entry_index_o,
  output logic                    found_o,
  output logic                    table_full_o,
  output logic                    key_too_long_o,
  output logic [SYM_W-1:0]        key_symbol_o,
  output logic                    key_symbol_present_o,
  output logic                    last_result_o
);

`include "vector_interning_hash_table_defines.svh"

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_HOME    = 4'd2;
  localparam logic [3:0] S_SLOT    = 4'd3;
  localparam logic [3:0] S_SLOTCHK = 4'd4;
  localparam logic [3:0] S_LEN     = 4'd5;
  localparam logic [3:0] S_LENCHK  = 4'd6;
  localparam logic [3:0] S_KEY     = 4'd7;
  localparam logic [3:0] S_KEYCHK  = 4'd8;
  localparam logic [3:0] S_MISS    = 4'd9;
  localparam logic [3:0] S_WR      = 4'd10;
  localparam logic [3:0] S_WRFIN   = 4'd11;
  localparam logic [3:0] S_RLEN    = 4'd12;
  localparam logic [3:0] S_RLENCHK = 4'd13;
  localparam logic [3:0] S_RKEY    = 4'd14;
  localparam logic [3:0] S_RKEYCHK = 4'd15;

  logic [3:0]         state_q, state_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SLOT_W-1:0]  probe_q, probe_d;
  logic [ENTRY_W-1:0] ent_q, ent_d;
  logic [KIDX_W-1:0]  cmp_q, cmp_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [FUNC_W-1:0]  func_q, func_d;
  logic               empty_q, empty_d;
  logic [LEN_W-1:0]   rlen_q, rlen_d;

  logic               out_valid_q;
  logic [ENTRY_W-1:0] o_idx_q;
  logic               o_found_q, o_full_q, o_tl_q, o_sp_q, o_last_q;
  logic [SYM_W-1:0]   o_sym_q;

  logic               emit;
  logic [ENTRY_W-1:0] e_idx;
  logic               e_found, e_full, e_tl, e_sp, e_last;
  logic [SYM_W-1:0]   e_sym;

  logic               accept, out_free;
  logic               kb_sym_en, kb_clr;
  logic [SLOT_W-1:0]  kb_home;
  logic [LEN_W-1:0]   kb_len;
  logic               kb_ovf;
  logic [SYM_W-1:0]   kb_sym;
  vih_store_req_t     sreq;
  logic [SLOTE_W-1:0] slot_rd;
  logic [LEN_W-1:0]   len_rd;
  logic [SYM_W-1:0]   key_rd;
  logic               advance;
  logic               cmp_end, rcmp_end;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cmp_end    = ({1'b0, cmp_q} == kb_len - LEN_W'(1));
  assign rcmp_end   = ({1'b0, cmp_q} == rlen_q - LEN_W'(1));

  vih_keybuf u_keybuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sym_en_i   (kb_sym_en),
    .sym_i      (symbol_i),
    .clr_i      (kb_clr),
    .rd_idx_i   (cmp_q),
    .home_slot_o(kb_home),
    .len_o      (kb_len),
    .ovf_o      (kb_ovf),
    .rd_sym_o   (kb_sym)
  );

  vih_store u_store (
    .clk_i    (clk_i),
    .req_i    (sreq),
    .slot_rd_o(slot_rd),
    .len_rd_o (len_rd),
    .key_rd_o (key_rd)
  );

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    probe_d  = probe_q;
    ent_d    = ent_q;
    cmp_d    = cmp_q;
    count_d  = count_q;
    func_d   = func_q;
    empty_d  = empty_q;
    rlen_d   = rlen_q;
    kb_sym_en = 1'b0;
    kb_clr   = 1'b0;
    advance  = 1'b0;
    emit     = 1'b0;
    e_idx    = '0;
    e_found  = 1'b0;
    e_full   = 1'b0;
    e_tl     = 1'b0;
    e_sym    = '0;
    e_sp     = 1'b0;
    e_last   = 1'b1;

    sreq            = '0;
    sreq.slot_raddr = slot_q;
    sreq.len_raddr  = ent_q;
    sreq.key_raddr  = {ent_q, cmp_q};
    sreq.key_waddr  = {count_q[ENTRY_W-1:0], cmp_q};
    sreq.key_wdata  = kb_sym;
    sreq.len_waddr  = count_q[ENTRY_W-1:0];
    sreq.len_wdata  = kb_len;
    sreq.slot_waddr = slot_q;
    sreq.slot_wdata = {1'b1, count_q[ENTRY_W-1:0]};

    unique case (state_q)
      S_CLR: begin
        sreq.slot_we    = 1'b1;
        sreq.slot_waddr = probe_q;
        sreq.slot_wdata = '0;
        probe_d = probe_q + SLOT_W'(1);
        if (probe_q == SLOT_W'(SLOT_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_READ) begin
            if ({1'b0, read_index_i} >= count_q) begin
              emit = 1'b1;
            end else begin
              ent_d   = read_index_i;
              state_d = S_RLEN;
            end
          end else if (func_i == FUNC_LOOKUP || func_i == FUNC_INSERT) begin
            kb_sym_en = symbol_present_i;
            if (last_symbol_i) begin
              if (kb_ovf || (symbol_present_i && kb_len == LEN_W'(MAX_KEY_LEN))) begin
                emit   = 1'b1;
                e_tl   = 1'b1;
                kb_clr = 1'b1;
              end else begin
                func_d  = func_i;
                state_d = S_HOME;
              end
            end
          end
        end
      end
      S_HOME: begin
        slot_d  = kb_home;
        probe_d = '0;
        state_d = S_SLOT;
      end
      S_SLOT: begin
        sreq.slot_re = 1'b1;
        state_d      = S_SLOTCHK;
      end
      S_SLOTCHK: begin
        if (!slot_rd[SLOTE_W-1]) begin
          empty_d = 1'b1;
          state_d = S_MISS;
        end else if ({1'b0, slot_rd[ENTRY_W-1:0]} >= count_q) begin
          advance = 1'b1;
        end else begin
          ent_d   = slot_rd[ENTRY_W-1:0];
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        sreq.len_re = 1'b1;
        state_d     = S_LENCHK;
      end
      S_LENCHK: begin
        cmp_d = '0;
        if (len_rd != kb_len) begin
          advance = 1'b1;
        end else if (kb_len == '0) begin
          emit    = 1'b1;
          e_idx   = ent_q;
          e_found = 1'b1;
          kb_clr  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        sreq.key_re = 1'b1;
        state_d     = S_KEYCHK;
      end
      S_KEYCHK: begin
        if (key_rd != kb_sym) begin
          advance = 1'b1;
        end else if (cmp_end) begin
          emit    = 1'b1;
          e_idx   = ent_q;
          e_found = 1'b1;
          kb_clr  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmp_d   = cmp_q + KIDX_W'(1);
          state_d = S_KEY;
        end
      end
      S_MISS: begin
        cmp_d = '0;
        if (func_q == FUNC_LOOKUP) begin
          emit    = 1'b1;
          kb_clr  = 1'b1;
          state_d = S_IDLE;
        end else if (count_q >= CNT_W'(ENTRY_CAPACITY) || !empty_q) begin
          emit    = 1'b1;
          e_full  = 1'b1;
          kb_clr  = 1'b1;
          state_d = S_IDLE;
        end else if (kb_len == '0) begin
          state_d = S_WRFIN;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        sreq.key_we = 1'b1;
        cmp_d = cmp_q + KIDX_W'(1);
        if (cmp_end) state_d = S_WRFIN;
      end
      S_WRFIN: begin
        sreq.len_we  = 1'b1;
        sreq.slot_we = 1'b1;
        emit    = 1'b1;
        e_idx   = count_q[ENTRY_W-1:0];
        count_d = count_q + CNT_W'(1);
        kb_clr  = 1'b1;
        state_d = S_IDLE;
      end
      S_RLEN: begin
        sreq.len_re = 1'b1;
        state_d     = S_RLENCHK;
      end
      S_RLENCHK: begin
        cmp_d  = '0;
        rlen_d = len_rd;
        if (len_rd == '0) begin
          if (out_free) begin
            emit    = 1'b1;
            e_idx   = ent_q;
            e_found = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_RKEY;
        end
      end
      S_RKEY: begin
        sreq.key_re = 1'b1;
        state_d     = S_RKEYCHK;
      end
      S_RKEYCHK: begin
        if (out_free) begin
          emit    = 1'b1;
          e_idx   = ent_q;
          e_found = 1'b1;
          e_sym   = key_rd;
          e_sp    = 1'b1;
          e_last  = rcmp_end;
          cmp_d   = cmp_q + KIDX_W'(1);
          state_d = rcmp_end ? S_IDLE : S_RKEY;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Step down one slot with wrap; a full lap means no empty slot exists.
    if (advance) begin
      slot_d  = slot_q - SLOT_W'(1);
      probe_d = probe_q + SLOT_W'(1);
      if (probe_q == SLOT_W'(SLOT_COUNT - 1)) begin
        empty_d = 1'b0;
        state_d = S_MISS;
      end else begin
        state_d = S_SLOT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      probe_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      probe_q <= probe_d;
      count_q <= count_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    ent_q   <= ent_d;
    cmp_q   <= cmp_d;
    func_q  <= func_d;
    empty_q <= empty_d;
    rlen_q  <= rlen_d;
    if (emit) begin
      o_idx_q   <= e_idx;
      o_found_q <= e_found;
      o_full_q  <= e_full;
      o_tl_q    <= e_tl;
      o_sym_q   <= e_sym;
      o_sp_q    <= e_sp;
      o_last_q  <= e_last;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign entry_index_o        = o_idx_q;
  assign found_o              = o_found_q;
  assign table_full_o         = o_full_q;
  assign key_too_long_o       = o_tl_q;
  assign key_symbol_o         = o_sym_q;
  assign key_symbol_present_o = o_sp_q;
  assign last_result_o        = o_last_q;

  `VIH_ASSERT(a_count_cap, count_q <= CNT_W'(ENTRY_CAPACITY))
  `VIH_ASSERT(a_ready_no_pending, in_ready_o |-> !out_valid_o)
  `VIH_ASSERT(a_wr_nonempty, (state_q == S_WR) |-> (kb_len != '0))
  `VIH_ASSERT_NEXT(a_ins_count, state_q == S_WRFIN, count_q == $past(count_q) + CNT_W'(1))

endmodule

`default_nettype wire

// ===== tb/vih_checker.sv =====
// Checker for the vector interning hash table: watches both channels and predicts results.
// It compares each result against its expectation and counts mismatches.
// Depends on vih_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vih_checker
  import vih_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [FUNC_W-1:0]  func_i,
  input  wire logic [SYM_W-1:0]   symbol_i,
  input  wire logic               symbol_present_i,
  input  wire logic               last_symbol_i,
  input  wire logic [ENTRY_W-1:0] read_index_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [ENTRY_W-1:0] entry_index_i,
  input  wire logic               found_i,
  input  wire logic               table_full_i,
  input  wire logic               key_too_long_i,
  input  wire logic [SYM_W-1:0]   key_symbol_i,
  input  wire logic               key_symbol_present_i,
  input  wire logic               last_result_i,
  output int                      errors_o,
  output int                      pending_o
);

  localparam logic [63:0] HASH_MASK = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [ENTRY_W-1:0] idx;
    logic               found;
    logic               full;
    logic               too_long;
    logic [SYM_W-1:0]   sym;
    logic               sym_present;
    logic               last;
  } vih_result_t;

  vih_result_t result_q[$];
  int errors;

  // Shadow table state
  logic [SYM_W-1:0]   kbuf[MAX_KEY_LEN];
  int                 klen;
  logic               koverflow;
  logic [HASH_W-1:0]  hash_acc;
  logic [SYM_W-1:0]   kstore[ENTRY_CAPACITY][MAX_KEY_LEN];
  int                 klen_store[ENTRY_CAPACITY];
  logic               slot_used[SLOT_COUNT];
  logic [ENTRY_W-1:0] slot_entry[SLOT_COUNT];
  int                 n_entries;

  assign errors_o  = errors;
  assign pending_o = result_q.size();

  function automatic vih_result_t mk(int idx, bit f, bit fu, bit tl, int s, bit sp, bit l);
    vih_result_t r;
    r.idx = ENTRY_W'(idx); r.found = f; r.full = fu; r.too_long = tl;
    r.sym = SYM_W'(s); r.sym_present = sp; r.last = l;
    return r;
  endfunction

  function automatic bit entry_matches(int e);
    if (e >= n_entries || klen_store[e] != klen) return 0;
    for (int n = 0; n < klen; n++)
      if (kstore[e][n] != kbuf[n]) return 0;
    return 1;
  endfunction

  task automatic clear_key();
    klen = 0; koverflow = 0; hash_acc = '0;
  endtask

  task automatic intern_request(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] s, logic pres,
                                logic lst, logic [ENTRY_W-1:0] ridx);
    int slot, hit_idx, empty_slot, len;
    bit hit, has_empty;
    logic [63:0] h;
    if (f == FUNC_NONE) return;
    if (f == FUNC_READ) begin
      if (ridx >= n_entries) begin
        result_q.push_back(mk(0, 0, 0, 0, 0, 0, 1));
      end else begin
        len = klen_store[ridx];
        if (len == 0) result_q.push_back(mk(ridx, 1, 0, 0, 0, 0, 1));
        for (int n = 0; n < len; n++)
          result_q.push_back(mk(ridx, 1, 0, 0, kstore[ridx][n], 1, n + 1 == len));
      end
      return;
    end
    if (pres) begin
      h = ((64'(hash_acc) + 64'(s)) * 64'(HASH_MULT)) & HASH_MASK;
      hash_acc = h[HASH_W-1:0];
      if (klen < MAX_KEY_LEN) begin
        kbuf[klen] = s; klen++;
      end else begin
        koverflow = 1;
      end
    end
    if (!lst) return;
    if (koverflow) begin
      result_q.push_back(mk(0, 0, 0, 1, 0, 0, 1));
      clear_key();
      return;
    end
    // downward linear probe with wrap
    slot = hash_acc % SLOT_COUNT;
    hit = 0; has_empty = 0; hit_idx = 0; empty_slot = 0;
    for (int n = 0; n < SLOT_COUNT; n++) begin
      if (!slot_used[slot]) begin
        has_empty = 1; empty_slot = slot; break;
      end
      if (entry_matches(slot_entry[slot])) begin
        hit = 1; hit_idx = slot_entry[slot]; break;
      end
      slot = (slot == 0) ? SLOT_COUNT - 1 : slot - 1;
    end
    if (hit) begin
      result_q.push_back(mk(hit_idx, 1, 0, 0, 0, 0, 1));
    end else if (f == FUNC_LOOKUP) begin
      result_q.push_back(mk(0, 0, 0, 0, 0, 0, 1));
    end else if (n_entries >= ENTRY_CAPACITY || !has_empty) begin
      result_q.push_back(mk(0, 0, 1, 0, 0, 0, 1));
    end else begin
      for (int n = 0; n < klen; n++) kstore[n_entries][n] = kbuf[n];
      klen_store[n_entries] = klen;
      slot_entry[empty_slot] = ENTRY_W'(n_entries);
      slot_used[empty_slot] = 1;
      result_q.push_back(mk(n_entries, 0, 0, 0, 0, 0, 1));
      n_entries++;
    end
    clear_key();
  endtask

  task automatic report(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    n_entries = 0;
    clear_key();
    for (int i = 0; i < SLOT_COUNT; i++) slot_used[i] = 0;
  end

  always @(posedge clk_i) begin
    vih_result_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("[%0t] result with no request pending", $realtime);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (entry_index_i != want.idx) report("entry_index", entry_index_i, want.idx);
          if (found_i != want.found) report("found", found_i, want.found);
          if (table_full_i != want.full) report("table_full", table_full_i, want.full);
          if (key_too_long_i != want.too_long)
            report("key_too_long", key_too_long_i, want.too_long);
          if (key_symbol_i != want.sym) report("key_symbol", key_symbol_i, want.sym);
          if (key_symbol_present_i != want.sym_present)
            report("key_symbol_present", key_symbol_present_i, want.sym_present);
          if (last_result_i != want.last) report("last_result", last_result_i, want.last);
        end
      end
      if (in_valid_i && in_ready_i)
        intern_request(func_i, symbol_i, symbol_present_i, last_symbol_i, read_index_i);
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, request stimulus and the final verdict.
// Depends on vih_pkg, vih_checker and the vector_interning_hash_table RTL.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import vih_pkg::*;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [FUNC_W-1:0]  func = FUNC_LOOKUP;
  logic [SYM_W-1:0]   symbol = '0;
  logic               symbol_present = 0;
  logic               last_symbol = 0;
  logic [ENTRY_W-1:0] read_index = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [ENTRY_W-1:0] entry_index;
  logic               found, table_full, key_too_long, key_symbol_present, last_result;
  logic [SYM_W-1:0]   key_symbol;
  int                 errors, pending;

  // keys offered so far, reused for hits
  logic [SYM_W-1:0] pool_sym[512][MAX_KEY_LEN];
  int               pool_len[512];
  int               pool_n = 0;
  int               burst_left = 0;
  int               n_sent = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  vector_interning_hash_table dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .symbol_i(symbol), .symbol_present_i(symbol_present),
    .last_symbol_i(last_symbol), .read_index_i(read_index),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .entry_index_o(entry_index), .found_o(found), .table_full_o(table_full),
    .key_too_long_o(key_too_long), .key_symbol_o(key_symbol),
    .key_symbol_present_o(key_symbol_present), .last_result_o(last_result)
  );

  vih_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .func_i(func), .symbol_i(symbol), .symbol_present_i(symbol_present),
    .last_symbol_i(last_symbol), .read_index_i(read_index),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .entry_index_i(entry_index), .found_i(found), .table_full_i(table_full),
    .key_too_long_i(key_too_long), .key_symbol_i(key_symbol),
    .key_symbol_present_i(key_symbol_present), .last_result_i(last_result),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver: random stall segments plus one long hold-off
  initial begin
    int seg, mode, cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      seg = $urandom_range(1, 30);
      mode = $urandom_range(0, 2);
      repeat (seg) begin
        @(posedge clk_i);
        cyc++;
        if (cyc >= 650 && cyc < 950) out_ready <= 0;
        else if (mode == 0) out_ready <= 1;
        else if (mode == 1) out_ready <= 1'($urandom_range(0, 1));
        else out_ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic send(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] s, logic p, logic l,
                      logic [ENTRY_W-1:0] ri);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1;
    func <= f; symbol <= s; symbol_present <= p; last_symbol <= l; read_index <= ri;
    do @(posedge clk_i); while (!in_ready);
    n_sent++;
  endtask

  // Offers pool key k; noisy adds empty symbols and stray items mid-key
  task automatic send_key(logic [FUNC_W-1:0] f, int k, bit noisy);
    int n;
    n = pool_len[k];
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 7) == 0)
        send(FUNC_W'($urandom_range(0, 1)), SYM_W'($urandom), 1'b0, 1'b0,
             ENTRY_W'($urandom));
      if (noisy && $urandom_range(0, 11) == 0)
        send($urandom_range(0, 1) ? FUNC_NONE : FUNC_READ, SYM_W'($urandom),
             1'($urandom), 1'($urandom), ENTRY_W'($urandom_range(0, pool_n)));
      send((i == n - 1) ? f : FUNC_W'($urandom_range(0, 1)), pool_sym[k][i], 1'b1,
           i == n - 1, ENTRY_W'($urandom));
    end
    if (n == 0) send(f, SYM_W'($urandom), 1'b0, 1'b1, ENTRY_W'($urandom));
  endtask

  function automatic int new_key(int len, int alpha);
    pool_len[pool_n] = len;
    for (int i = 0; i < len && i < MAX_KEY_LEN; i++)
      pool_sym[pool_n][i] = (alpha > 0) ? SYM_W'($urandom_range(0, alpha))
                                        : SYM_W'($urandom_range(0, 32766));
    pool_n++;
    return pool_n - 1;
  endfunction

  // Keys longer than the bound go out directly; they are not pooled
  task automatic send_long(logic [FUNC_W-1:0] f, int len);
    for (int i = 0; i < len; i++)
      send(f, SYM_W'($urandom_range(0, 32766)), 1'b1, i == len - 1, ENTRY_W'($urandom));
  endtask

  initial begin
    int k, pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // directed
    k = new_key(0, 0);
    send_key(FUNC_LOOKUP, k, 1'b0);
    send_key(FUNC_INSERT, k, 1'b0);
    send_key(FUNC_LOOKUP, k, 1'b0);
    k = new_key(1, 0); pool_sym[k][0] = '0;
    send_key(FUNC_INSERT, k, 1'b0);
    k = new_key(1, 0); pool_sym[k][0] = SYM_W'(32766);
    send_key(FUNC_INSERT, k, 1'b0);
    send_key(FUNC_INSERT, k, 1'b0);
    k = new_key(MAX_KEY_LEN, 0);
    send_key(FUNC_INSERT, k, 1'b1);
    send_long(FUNC_INSERT, MAX_KEY_LEN + 1);
    send_long(FUNC_LOOKUP, MAX_KEY_LEN + 2);
    send(FUNC_NONE, '1, 1'b1, 1'b1, '1);
    send(FUNC_READ, '0, 1'b0, 1'b0, 8'd0);
    send(FUNC_READ, '1, 1'b1, 1'b1, 8'd2);
    send(FUNC_READ, '0, 1'b0, 1'b0, 8'd3);
    send(FUNC_READ, '0, 1'b0, 1'b0, 8'd255);
    send_key(FUNC_LOOKUP, k, 1'b0);

    // random mix, mostly well-formed keys
    while (n_sent < 100) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        k = new_key($urandom_range(0, 5), $urandom_range(0, 1) ? 3 : 0);
        send_key(FUNC_INSERT, k, 1'b1);
      end else if (pick < 60) begin
        send_key(FUNC_W'($urandom_range(0, 1)), $urandom_range(0, pool_n - 1), 1'b1);
      end else if (pick < 72) begin
        k = new_key($urandom_range(0, 4), 3);
        send_key(FUNC_LOOKUP, k, 1'b1);
      end else if (pick < 88) begin
        send(FUNC_READ, SYM_W'($urandom), 1'($urandom), 1'($urandom),
             ($urandom_range(0, 3) == 0) ? ENTRY_W'($urandom)
                                         : ENTRY_W'($urandom_range(0, pool_n)));
      end else if (pick < 93) begin
        send_long(FUNC_W'($urandom_range(0, 1)), $urandom_range(MAX_KEY_LEN + 1, 20));
      end else begin
        send(FUNC_NONE, SYM_W'($urandom), 1'($urandom), 1'($urandom), ENTRY_W'($urandom));
      end
    end

    send_key(FUNC_INSERT, 1, 1'b0);
    send_key(FUNC_LOOKUP, 2, 1'b0);
    send(FUNC_READ, '0, 1'b0, 1'b0, 8'd255);
    send(FUNC_READ, '0, 1'b0, 1'b0, 8'd2);
    in_valid <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("Covered %0d requests: lookups, inserts, repeats, reads, empty and overlong keys.",
             n_sent);
    $display("Output stalls included one long hold-off that backed up the input.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
